### hdl/dspm_pkg.sv
// Shared constants, codes and cell interface types for the dot-star pattern matcher.
package dspm_pkg;

   localparam int MAX_TOKENS = 16;

   localparam logic [7:0] STAR_CODE = 8'd42;
   localparam logic [7:0] ANY_CODE  = 8'd46;

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_TEXT    = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_STAR,
      OP_TEXT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;      // cell holds a token
      logic tail_star;  // last token and already starred
      logic adv;        // text byte consumed by a plain token: activate next position
      logic carry;      // closure passed on to the next position
      logic hit;        // this position equals the token count and is active
   } cell_stat_type;

endpackage

### hdl/dspm_cell.sv
// One pattern cell: a token, its star flag and the active bit of its position.
module dspm_cell import dspm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic          head,
   input  logic          prev_valid,
   input  logic          next_valid,
   input  logic          carry_in,
   input  logic          adv_in,
   output cell_stat_type stat
);

   logic       valid_ff, valid_in;
   logic       star_ff, star_in;
   logic       any_ff, any_in;
   logic [7:0] byte_ff, byte_in;
   logic       act_ff, act_in;

   logic closed;
   logic match;
   logic is_tail;
   logic load_here;

   assign closed    = act_ff | carry_in;
   assign match     = valid_ff & closed & (any_ff | (byte_ff == ctl.data));
   assign is_tail   = valid_ff & ~next_valid;
   assign load_here = prev_valid & ~valid_ff;

   always_comb begin
      valid_in = valid_ff;
      star_in  = star_ff;
      any_in   = any_ff;
      byte_in  = byte_ff;
      act_in   = act_ff;
      case (ctl.op)
         OP_CLEAR: begin
            valid_in = 1'b0;
            star_in  = 1'b0;
            act_in   = head;
         end
         OP_LOAD: begin
            if (load_here) begin
               valid_in = 1'b1;
               star_in  = 1'b0;
               byte_in  = ctl.data;
               any_in   = (ctl.data == ANY_CODE);
            end
         end
         OP_STAR: begin
            if (is_tail) begin
               star_in = 1'b1;
            end
         end
         OP_TEXT: begin
            act_in = (match & star_ff) | adv_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         star_ff  <= 1'b0;
         act_ff   <= head;
      end else begin
         valid_ff <= valid_in;
         star_ff  <= star_in;
         act_ff   <= act_in;
      end
      any_ff  <= any_in;
      byte_ff <= byte_in;
   end

   assign stat.valid     = valid_ff;
   assign stat.tail_star = is_tail & star_ff;
   assign stat.adv       = match & ~star_ff;
   assign stat.carry     = closed & star_ff;
   assign stat.hit       = closed & prev_valid & ~valid_ff;

endmodule

### hdl/dot_star_pattern_matcher_core.sv
// Top level: request decode, error tracking and the chain of pattern cells.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid req_ready req_mode        | in
//           | req_data_byte                       |
//   response| rsp_valid rsp_ready rsp_matched     | out
//           | rsp_error                           |
//
// One request per cycle while responses are taken; its response appears the cycle after acceptance.
// The response is computed from the cell registers, so the next request is
// taken only in a cycle where the pending response is free or is taken.
// Star closure ripples combinationally through all MAX_TOKENS cells.
// Synchronous reset gives the same matcher state as a clear request, with no response pending.
module dot_star_pattern_matcher_core import dspm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_error
);

   logic pend_ff, pend_in;
   logic error_ff, error_in;
   logic text_ff, text_in;
   logic act_end_ff, act_end_in;   // active bit of the position after the last cell

   cell_ctl_type  ctl;
   cell_stat_type stat [MAX_TOKENS];

   logic [MAX_TOKENS-1:0] valid_vec;
   logic [MAX_TOKENS-1:0] tail_star_vec;
   logic [MAX_TOKENS-1:0] hit_vec;
   logic                  req_fire;
   logic                  last_star;
   logic                  closed_end;
   logic                  hit;

   assign req_fire = req_valid & req_ready;

   genvar k;
   generate
      for (k = 0; k < MAX_TOKENS; k++) begin : g_cell
         logic prev_valid, next_valid, carry_in, adv_in, head;
         if (k == 0) begin : g_first
            assign prev_valid = 1'b1;
            assign carry_in   = 1'b0;
            assign adv_in     = 1'b0;
            assign head       = 1'b1;
         end else begin : g_rest
            assign prev_valid = stat[k-1].valid;
            assign carry_in   = stat[k-1].carry;
            assign adv_in     = stat[k-1].adv;
            assign head       = 1'b0;
         end
         if (k == MAX_TOKENS - 1) begin : g_last
            assign next_valid = 1'b0;
         end else begin : g_mid
            assign next_valid = stat[k+1].valid;
         end

         dspm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .head       (head),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .carry_in   (carry_in),
            .adv_in     (adv_in),
            .stat       (stat[k])
         );

         assign valid_vec[k]     = stat[k].valid;
         assign tail_star_vec[k] = stat[k].tail_star;
         assign hit_vec[k]       = stat[k].hit;
      end
   endgenerate

   assign last_star  = |tail_star_vec;
   assign closed_end = act_end_ff | stat[MAX_TOKENS-1].carry;
   assign hit        = (|hit_vec) | (valid_vec[MAX_TOKENS-1] & closed_end);

   always_comb begin
      ctl.op     = OP_NONE;
      ctl.data   = req_data_byte;
      error_in   = error_ff;
      text_in    = text_ff;
      act_end_in = act_end_ff;
      pend_in    = pend_ff;

      if (rsp_valid && rsp_ready) begin
         pend_in = 1'b0;
      end

      if (req_fire) begin
         pend_in = 1'b1;
         case (req_mode)
            MODE_CLEAR: begin
               ctl.op     = OP_CLEAR;
               error_in   = 1'b0;
               text_in    = 1'b0;
               act_end_in = 1'b0;
            end
            MODE_PATTERN: begin
               if (text_ff) begin
                  error_in = 1'b1;
               end else if (req_data_byte == STAR_CODE) begin
                  // leading or doubled star is dropped and sets the error flag
                  if (!valid_vec[0] || last_star) begin
                     error_in = 1'b1;
                  end else begin
                     ctl.op = OP_STAR;
                  end
               end else if (valid_vec[MAX_TOKENS-1]) begin
                  error_in = 1'b1;
               end else begin
                  ctl.op = OP_LOAD;
               end
            end
            MODE_TEXT: begin
               ctl.op     = OP_TEXT;
               text_in    = 1'b1;
               act_end_in = stat[MAX_TOKENS-1].adv;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         error_ff   <= 1'b0;
         text_ff    <= 1'b0;
         act_end_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         error_ff   <= error_in;
         text_ff    <= text_in;
         act_end_ff <= act_end_in;
      end
   end

   assign req_ready   = ~pend_ff | rsp_ready;
   assign rsp_valid   = pend_ff;
   assign rsp_matched = hit & ~error_ff;
   assign rsp_error   = error_ff;

   // tokens always fill the chain from cell zero without gaps
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + MAX_TOKENS'(1)) & valid_vec) == '0)
      else $error("token valid bits not contiguous");

   a_one_tail: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tail_star_vec))
      else $error("more than one starred tail");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode == MODE_CLEAR |=> rsp_valid && rsp_matched && !rsp_error)
      else $error("clear did not give empty match");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff && !(req_fire && req_mode == MODE_CLEAR) |=> error_ff)
      else $error("error flag dropped without clear");

endmodule

### verif/tb_dot_star_pattern_matcher_core.sv
// Testbench for the dot-star pattern matcher: directed table, random sequences, predictor.
`timescale 1ns / 1ps

module tb_dot_star_pattern_matcher_core;
   import dspm_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_C = 8'h63;
   localparam logic [7:0] CH_X = 8'h78;
   localparam int RANDOM_REQUESTS = 550;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic matched;
      logic error;
   } match_result_t;

   typedef struct packed {
      logic [1:0]    mode;
      logic [7:0]    data;
      logic          fixed;
      match_result_t want;
   } stim_row_t;

   // fixed rows carry a hand-written result, the rest go through the predictor
   localparam stim_row_t DIRECTED_ROWS [27] = '{
      '{MODE_CLEAR,   8'h00,     1'b1, '{1'b1, 1'b0}},
      '{MODE_UNUSED,  8'hFF,     1'b1, '{1'b1, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b1, '{1'b0, 1'b1}},  // leading star
      '{MODE_CLEAR,   8'hFF,     1'b1, '{1'b1, 1'b0}},
      '{MODE_PATTERN, CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b1, '{1'b0, 1'b1}},  // doubled star
      '{MODE_CLEAR,   8'h00,     1'b1, '{1'b1, 1'b0}},
      // ab*a*c*a against aaa, the case a greedy backtrack gets wrong
      '{MODE_PATTERN, CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, CH_B,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, CH_C,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, STAR_CODE, 1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    CH_A,      1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, CH_X,      1'b1, '{1'b0, 1'b1}},  // pattern after text
      '{MODE_CLEAR,   8'h00,     1'b1, '{1'b1, 1'b0}},
      '{MODE_PATTERN, ANY_CODE,  1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, 8'h00,     1'b0, '{1'b0, 1'b0}},
      '{MODE_PATTERN, 8'hFF,     1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    8'hFF,     1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    8'h00,     1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,    8'hFF,     1'b0, '{1'b0, 1'b0}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = MODE_CLEAR;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matched;
   logic       rsp_error;

   // side info traveling with the request on the input channel
   logic          row_fixed = 1'b0;
   match_result_t row_want = '0;

   logic quiet_stretch = 1'b0;
   int   hold_requests = 0;
   int   holds_served = 0;
   int   sent_count = 0;
   int   mismatch_count = 0;
   int   stall_cycles = 0;

   match_result_t expected_results [$];

   // predictor state
   logic [7:0]          pat_byte [MAX_TOKENS];
   logic                pat_any  [MAX_TOKENS];
   logic                pat_star [MAX_TOKENS];
   int                  pat_count;
   logic [MAX_TOKENS:0] live_pos;
   logic                sticky_err;
   logic                text_started;

   dot_star_pattern_matcher_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_matched   (rsp_matched),
      .rsp_error     (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_matcher();
      for (int k = 0; k < MAX_TOKENS; k++) begin
         pat_byte[k] = 8'h00;
         pat_any[k]  = 1'b0;
         pat_star[k] = 1'b0;
      end
      pat_count    = 0;
      live_pos     = (MAX_TOKENS + 1)'(1);
      sticky_err   = 1'b0;
      text_started = 1'b0;
   endfunction

   // skipping a starred token makes the next position live as well
   function automatic logic [MAX_TOKENS:0] star_closure(input logic [MAX_TOKENS:0] pos);
      for (int k = 0; k < pat_count; k++) begin
         if (pos[k] && pat_star[k]) pos[k + 1] = 1'b1;
      end
      return pos;
   endfunction

   function automatic match_result_t advance_matcher(input logic [1:0] mode,
                                                     input logic [7:0] data);
      logic [MAX_TOKENS:0] closed;
      logic [MAX_TOKENS:0] next_pos;
      match_result_t       res;
      case (mode)
         MODE_CLEAR: clear_matcher();
         MODE_PATTERN: begin
            if (text_started) begin
               sticky_err = 1'b1;
            end else if (data == STAR_CODE) begin
               if (pat_count == 0 || pat_star[pat_count - 1]) sticky_err = 1'b1;
               else pat_star[pat_count - 1] = 1'b1;
            end else if (pat_count >= MAX_TOKENS) begin
               sticky_err = 1'b1;
            end else begin
               pat_byte[pat_count] = data;
               pat_any[pat_count]  = (data == ANY_CODE);
               pat_star[pat_count] = 1'b0;
               pat_count++;
            end
         end
         MODE_TEXT: begin
            closed       = star_closure(live_pos);
            next_pos     = '0;
            text_started = 1'b1;
            for (int k = 0; k < pat_count; k++) begin
               if (closed[k] && (pat_any[k] || pat_byte[k] == data)) begin
                  if (pat_star[k]) next_pos[k] = 1'b1;
                  else next_pos[k + 1] = 1'b1;
               end
            end
            live_pos = next_pos;
         end
         default: ;
      endcase
      closed      = star_closure(live_pos);
      res.matched = sticky_err ? 1'b0 : closed[pat_count];
      res.error   = sticky_err;
      return res;
   endfunction

   // response check first, so a response never pairs with a request of the same edge
   always @(posedge clock) begin
      match_result_t got;
      match_result_t want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_matched, rsp_error};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with nothing pending: matched=%0b error=%0b",
                           $realtime, got.matched, got.error);
            end else begin
               want = expected_results.pop_front();
               if (got.matched !== want.matched || got.error !== want.error) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: mismatch: matched exp %0b got %0b, error exp %0b got %0b",
                              $realtime, want.matched, got.matched, want.error, got.error);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = advance_matcher(req_mode, req_data_byte);
            expected_results.push_back(row_fixed ? row_want : want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random stalls, quiet stretch, and long hold-offs on request
   initial begin
      int hold_left;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [7:0] data,
                               input logic fixed = 1'b0, input match_result_t want = '0);
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      row_fixed     <= fixed;
      row_want      <= want;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // usually a clear, then a random pattern, then text that half the time follows the pattern
   task automatic run_match_sequence();
      logic [7:0] tok_byte [20];
      logic       tok_star [20];
      logic [7:0] text_bytes [$];
      logic [7:0] b;
      int         n_tok;
      int         r;
      int         reps;
      r = $urandom_range(0, 99);
      if (r < 92) send_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 70) n_tok = $urandom_range(1, 5);
      else if (r < 92) n_tok = $urandom_range(6, 16);
      else n_tok = $urandom_range(16, 19);  // 17 to 19 overflow
      for (int i = 0; i < n_tok; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) tok_byte[i] = CH_A + 8'($urandom_range(0, 2));
         else if (r < 80) tok_byte[i] = ANY_CODE;
         else tok_byte[i] = 8'($urandom_range(0, 255));
         tok_star[i] = ($urandom_range(0, 99) < 35);
      end
      if ($urandom_range(0, 99) < 4) send_request(MODE_PATTERN, STAR_CODE);
      for (int i = 0; i < n_tok; i++) begin
         send_request(MODE_PATTERN, tok_byte[i]);
         if (tok_star[i]) begin
            send_request(MODE_PATTERN, STAR_CODE);
            if ($urandom_range(0, 99) < 3) send_request(MODE_PATTERN, STAR_CODE);
         end
      end
      if ($urandom_range(0, 99) < 50) begin
         for (int i = 0; i < n_tok; i++) begin
            reps = tok_star[i] ? $urandom_range(0, 3) : 1;
            for (int j = 0; j < reps; j++) begin
               if (tok_byte[i] != ANY_CODE) b = tok_byte[i];
               else if ($urandom_range(0, 1) == 0) b = CH_A + 8'($urandom_range(0, 2));
               else b = 8'($urandom_range(0, 255));
               text_bytes.push_back(b);
            end
         end
         if ($urandom_range(0, 99) < 25) begin
            if (text_bytes.size() > 0)
               text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                  CH_A + 8'($urandom_range(0, 2));
            else
               text_bytes.push_back(CH_A);
         end
      end else begin
         reps = $urandom_range(0, 10);
         for (int j = 0; j < reps; j++) begin
            if ($urandom_range(0, 99) < 80) b = CH_A + 8'($urandom_range(0, 2));
            else b = 8'($urandom_range(0, 255));
            text_bytes.push_back(b);
         end
      end
      while (text_bytes.size() > 24) void'(text_bytes.pop_back());
      foreach (text_bytes[i]) begin
         send_request(MODE_TEXT, text_bytes[i]);
         if ($urandom_range(0, 99) < 3)
            send_request(MODE_UNUSED, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 5)
         send_request(MODE_PATTERN, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int random_start;
      int next_hold_at;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].data,
                      DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

      random_start = sent_count;
      next_hold_at = random_start + 150;
      while (sent_count - random_start < RANDOM_REQUESTS) begin
         quiet_stretch = (sent_count - random_start >= 250) &&
                         (sent_count - random_start < 380);
         if (sent_count >= next_hold_at) begin
            hold_requests++;
            next_hold_at += 270;
         end
         run_match_sequence();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
